// ===== sv/fcba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcba_pkg
// Shared types and constants of the chained block allocator.
// ----------------------------------------------------------------------------
package fcba_pkg;

  localparam int BLK_W  = 8;
  localparam int SIZE_W = 16;
  localparam int FI_W   = 5;
  localparam int ST_W   = 2;
  localparam int ACC_W  = 17;

  localparam logic [BLK_W-1:0] LINK_FREE = 8'd0;
  localparam logic [BLK_W-1:0] LINK_LAST = 8'd1;
  localparam logic [BLK_W-1:0] MIN_BLOCK = 8'd2;
  localparam logic [BLK_W-1:0] CFG_RESET = 8'd2;

  localparam logic FUNC_DELETE = 1'b0;
  localparam logic FUNC_EXTEND = 1'b1;

  localparam logic [ST_W-1:0] ST_UNUSED = 2'd0;
  localparam logic [ST_W-1:0] ST_CLOSED = 2'd1;
  localparam logic [ST_W-1:0] ST_OPEN   = 2'd2;

  typedef struct packed {
    logic              func;
    logic [FI_W-1:0]   file_index;
    logic [ST_W-1:0]   entry_status;
    logic [SIZE_W-1:0] req_bytes;
  } in_word_t;

  typedef struct packed {
    logic              ok;
    logic [SIZE_W-1:0] bytes_granted;
    logic              entry_now_unused;
  } out_word_t;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic entry_load;
    logic walk_start;
    logic dwalk_step;
    logic twalk_step;
    logic scan_init_empty;
    logic scan_init_tail;
    logic scan_step;
    logic ext_commit;
    logic del_commit;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic reject;
    logic is_del;
    logic first_zero;
    logic first_link;
    logic walk_more;
    logic scan_done;
    logic out_free;
  } status_t;

endpackage

// ===== sv/fcba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcba_ram
// Simple dual-port RAM, one write and one registered read port. A read of
// the address being written returns the new data.
// ----------------------------------------------------------------------------
module fcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fcba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcba_ctrl
// Sequencer for clearing, chain walks, free-block scan and result hand-off.
// ----------------------------------------------------------------------------
module fcba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fcba_pkg::status_t st_i,
  output fcba_pkg::cmd_t    cmd_o
);
  import fcba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FREAD,
    S_DWALK,
    S_DEND,
    S_TWALK,
    S_SINIT,
    S_SCAN,
    S_COMMIT,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (st_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_FREAD;
        end
      end
      S_FREAD: begin
        cmd_o.entry_load = 1'b1;
        if (st_i.reject) begin
          state_d = S_RESP;
        end else if (st_i.is_del) begin
          if (st_i.first_link) begin
            cmd_o.walk_start = 1'b1;
            state_d = S_DWALK;
          end else begin
            state_d = S_DEND;
          end
        end else if (st_i.first_zero) begin
          cmd_o.scan_init_empty = 1'b1;
          state_d = S_SCAN;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d = S_TWALK;
        end
      end
      S_DWALK: begin
        cmd_o.dwalk_step = 1'b1;
        if (!st_i.walk_more) state_d = S_DEND;
      end
      S_DEND: begin
        cmd_o.del_commit = 1'b1;
        state_d = S_RESP;
      end
      S_TWALK: begin
        cmd_o.twalk_step = 1'b1;
        if (!st_i.walk_more) state_d = S_SINIT;
      end
      S_SINIT: begin
        cmd_o.scan_init_tail = 1'b1;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (st_i.scan_done) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.ext_commit = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (st_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/fcba_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcba_datapath
// Chain table and directory RAMs, walk and scan registers, result register.
// ----------------------------------------------------------------------------
module fcba_datapath #(
  parameter int NUM_BLOCKS  = 256,
  parameter int NUM_FILES   = 32,
  parameter int BLOCK_BYTES = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fcba_pkg::cmd_t      cmd_i,
  output fcba_pkg::status_t   st_o,
  input  fcba_pkg::in_word_t  in_data_i,
  input  logic                cfg_valid_i,
  input  logic [7:0]          cfg_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fcba_pkg::out_word_t out_data_o
);
  import fcba_pkg::*;

  localparam int BAW   = $clog2(NUM_BLOCKS);
  localparam int FAW   = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int CLR_N = (NUM_BLOCKS > NUM_FILES) ? NUM_BLOCKS : NUM_FILES;
  localparam int CW    = $clog2(CLR_N);
  localparam int FW    = BLK_W + SIZE_W;

  function automatic logic is_link(input logic [BLK_W-1:0] b);
    return (b >= MIN_BLOCK) && ({1'b0, b} < (BLK_W+1)'(NUM_BLOCKS));
  endfunction

  function automatic logic [FAW-1:0] fi_addr(input logic [FI_W-1:0] f);
    logic [FAW+FI_W-1:0] ext;
    ext = {{FAW{1'b0}}, f};
    return ext[FAW-1:0];
  endfunction

  // Captured command.
  logic              func_q;
  logic [FI_W-1:0]   fi_q;
  logic [ST_W-1:0]   status_q;
  logic [SIZE_W-1:0] bytes_q;
  // Directory entry and walk / scan state.
  logic [BLK_W-1:0]  first_q, cur_q, prev_q, rd_addr_q, cfg_q;
  logic [SIZE_W-1:0] size_q;
  logic [BAW-1:0]    cnt_q;
  logic [ACC_W-1:0]  acc_q;
  logic [BLK_W:0]    scan_q;
  logic              rd_pend_q;
  logic [CW-1:0]     clr_q;
  logic              out_valid_q;
  out_word_t         out_q;

  logic              c_we;
  logic [BAW-1:0]    c_waddr, c_raddr;
  logic [BLK_W-1:0]  c_wdata, c_rdata;
  logic              f_we;
  logic [FAW-1:0]    f_waddr, f_raddr;
  logic [FW-1:0]     f_wdata, f_rdata;
  logic [BLK_W-1:0]  f_first;

  logic              reject, hit, enough, scan_end, scan_done;
  logic [ACC_W-1:0]  acc_step, acc_nx;
  logic [BLK_W-1:0]  lowest;
  logic [BLK_W:0]    tail_next, scan_tail;
  logic [SIZE_W-1:0] granted, size_new;
  logic [SIZE_W:0]   size_sum;
  logic              chain_clr, file_clr;

  fcba_ram #(.WIDTH(BLK_W), .DEPTH(NUM_BLOCKS)) u_chain_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  fcba_ram #(.WIDTH(FW), .DEPTH(NUM_FILES)) u_file_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  assign f_first = f_rdata[FW-1:SIZE_W];

  always_comb begin
    if ({{(9-FI_W){1'b0}}, fi_q} >= 9'(NUM_FILES)) begin
      reject = 1'b1;
    end else if (func_q == FUNC_DELETE) begin
      reject = (status_q != ST_CLOSED);
    end else begin
      reject = (status_q != ST_OPEN);
    end
  end

  assign lowest    = (cfg_q < MIN_BLOCK) ? MIN_BLOCK : cfg_q;
  assign tail_next = {1'b0, cur_q} + (BLK_W+1)'(1);
  assign scan_tail = (tail_next < {1'b0, lowest}) ? {1'b0, lowest} : tail_next;

  // The scan runs one block a cycle; the read of the block after a hit is
  // already in flight and simply ignored when the request is satisfied.
  assign hit       = rd_pend_q && (c_rdata == LINK_FREE);
  assign acc_step  = acc_q + ACC_W'(BLOCK_BYTES);
  assign acc_nx    = hit ? acc_step : acc_q;
  assign enough    = acc_nx >= {1'b0, bytes_q};
  assign scan_end  = scan_q >= (BLK_W+1)'(NUM_BLOCKS);
  assign scan_done = enough || scan_end;

  assign granted  = (acc_q > {1'b0, bytes_q}) ? bytes_q : acc_q[SIZE_W-1:0];
  assign size_sum = {1'b0, size_q} + {1'b0, granted};
  assign size_new = size_sum[SIZE_W] ? {SIZE_W{1'b1}} : size_sum[SIZE_W-1:0];

  assign chain_clr = {1'b0, clr_q} < (CW+1)'(NUM_BLOCKS);
  assign file_clr  = {1'b0, clr_q} < (CW+1)'(NUM_FILES);

  always_comb begin
    c_we    = 1'b0;
    c_waddr = '0;
    c_wdata = LINK_FREE;
    if (cmd_i.clr_step && chain_clr) begin
      c_we    = 1'b1;
      c_waddr = clr_q[BAW-1:0];
    end else if (cmd_i.dwalk_step) begin
      c_we    = 1'b1;
      c_waddr = cur_q[BAW-1:0];
    end else if (cmd_i.scan_step && hit && (prev_q != LINK_FREE)) begin
      c_we    = 1'b1;
      c_waddr = prev_q[BAW-1:0];
      c_wdata = rd_addr_q;
    end else if (cmd_i.ext_commit && (acc_q != '0)) begin
      c_we    = 1'b1;
      c_waddr = prev_q[BAW-1:0];
      c_wdata = LINK_LAST;
    end
  end

  always_comb begin
    c_raddr = '0;
    if (cmd_i.walk_start) begin
      c_raddr = f_first[BAW-1:0];
    end else if (cmd_i.dwalk_step || cmd_i.twalk_step) begin
      c_raddr = c_rdata[BAW-1:0];
    end else if (cmd_i.scan_step) begin
      c_raddr = scan_q[BAW-1:0];
    end
  end

  always_comb begin
    f_we    = 1'b0;
    f_waddr = fi_addr(fi_q);
    f_wdata = '0;
    if (cmd_i.clr_step && file_clr) begin
      f_we    = 1'b1;
      f_waddr = clr_q[FAW-1:0];
    end else if (cmd_i.del_commit) begin
      f_we    = 1'b1;
    end else if (cmd_i.ext_commit) begin
      f_we    = 1'b1;
      f_wdata = {first_q, size_new};
    end
  end

  assign f_raddr = cmd_i.capture ? fi_addr(in_data_i.file_index) : fi_addr(fi_q);

  always_comb begin
    st_o            = '0;
    st_o.clr_last   = ({1'b0, clr_q} == (CW+1)'(CLR_N - 1));
    st_o.reject     = reject;
    st_o.is_del     = (func_q == FUNC_DELETE);
    st_o.first_zero = (f_first == LINK_FREE);
    st_o.first_link = is_link(f_first);
    st_o.walk_more  = is_link(c_rdata) && (({1'b0, cnt_q} + (BAW+1)'(1)) <
                                           (BAW+1)'(NUM_BLOCKS));
    st_o.scan_done  = scan_done;
    st_o.out_free   = !out_valid_q || out_ready_i;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      cfg_q       <= CFG_RESET;
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + CW'(1);
      if (cfg_valid_i) cfg_q <= cfg_data_i;
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.scan_init_empty || cmd_i.scan_init_tail) begin
        rd_pend_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        rd_pend_q <= !scan_done;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= in_data_i.func;
      fi_q     <= in_data_i.file_index;
      status_q <= in_data_i.entry_status;
      bytes_q  <= in_data_i.req_bytes;
    end
    if (cmd_i.entry_load) begin
      first_q <= f_first;
      size_q  <= f_rdata[SIZE_W-1:0];
      acc_q   <= '0;
    end
    if (cmd_i.walk_start) begin
      cur_q <= f_first;
      cnt_q <= '0;
    end else if (cmd_i.dwalk_step || (cmd_i.twalk_step && is_link(c_rdata))) begin
      cur_q <= c_rdata;
      cnt_q <= cnt_q + BAW'(1);
    end
    if (cmd_i.scan_init_empty) begin
      prev_q <= LINK_FREE;
      scan_q <= {1'b0, lowest};
    end else if (cmd_i.scan_init_tail) begin
      prev_q <= cur_q;
      scan_q <= scan_tail;
    end else if (cmd_i.scan_step) begin
      if (hit) begin
        prev_q <= rd_addr_q;
        acc_q  <= acc_step;
        if (prev_q == LINK_FREE) first_q <= rd_addr_q;
      end
      if (!scan_done) begin
        rd_addr_q <= scan_q[BLK_W-1:0];
        scan_q    <= scan_q + (BLK_W+1)'(1);
      end
    end
    if (cmd_i.res_load) begin
      out_q.ok               <= !reject;
      out_q.bytes_granted    <= (!reject && (func_q == FUNC_EXTEND)) ? granted : '0;
      out_q.entry_now_unused <= !reject && (func_q == FUNC_DELETE);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/fat_chain_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_block_allocator
// Chained allocation table: frees a closed file's chain on delete, appends
// first-fit free blocks to an open file's chain on extend.
// ----------------------------------------------------------------------------
//  Channel   Signals                              Direction  Word
//  in        in_valid_i / in_ready_o / in_data_i  in         in_word_t
//  out       out_valid_o / out_ready_i / out_data_o out      out_word_t
//  cfg       cfg_valid_i / cfg_ready_o / cfg_data_i in       first usable block
//
// One word is in flight at a time. Delete walks the file's chain and frees
// each block on it; extend walks the existing chain, if any, to its tail,
// then scans table entries for free blocks. Both run through the single
// chain-table RAM port pair. After reset a clearing pass over every
// chain-table and directory entry runs before the first word is taken;
// cfg writes are always taken. A result held in the output register does
// not stop the next word from entering.
// ----------------------------------------------------------------------------
module fat_chain_block_allocator #(
  parameter int NUM_BLOCKS  = 256,
  parameter int NUM_FILES   = 32,
  parameter int BLOCK_BYTES = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  fcba_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fcba_pkg::out_word_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);
  import fcba_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready_o = 1'b1;

  fcba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  fcba_datapath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .NUM_FILES   (NUM_FILES),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chained block allocator. Every word accepted on
// the input channel is run through a local model of the chain table and the
// directory, and the result word it yields is queued. Each result word taken
// from the block is compared field by field with the oldest queued one.
// Directed words cover rejects, empty files, chain growth, a full table, the
// first-usable-block register and a long output stall; random traffic follows
// under several register settings, with and without random idling.
// ----------------------------------------------------------------------------
module tb_top;
  import fcba_pkg::*;

  localparam int N_BLOCKS    = 256;
  localparam int N_FILES     = 32;
  localparam int BLOCK_SZ    = 128;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYC  = 600;
  localparam logic [ST_W-1:0] ST_BAD = 2'd3;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [7:0] cfg_data_i = CFG_RESET;

  // Local copy of the allocation state.
  logic [BLK_W-1:0]  link_tbl [N_BLOCKS];
  logic [BLK_W-1:0]  head_blk [N_FILES];
  logic [SIZE_W-1:0] file_bytes [N_FILES];
  logic [7:0]        min_alloc_blk;

  out_word_t alloc_results [$];
  int        mismatches  = 0;
  int        idle_cycles = 0;
  bit        idle_on     = 1'b1;
  int        rx_hold_req = 0;
  int        rx_stall    = 0;

  fat_chain_block_allocator #(
    .NUM_BLOCKS (N_BLOCKS),
    .NUM_FILES  (N_FILES),
    .BLOCK_BYTES(BLOCK_SZ)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic out_word_t predict_alloc(input in_word_t w);
    out_word_t   res;
    int unsigned need, lowest, start, prev, got, granted, total;
    int unsigned cur, nxt, b, steps;
    res = '0;
    if (w.func == FUNC_DELETE) begin
      if (w.entry_status != ST_CLOSED) return res;
      cur = 32'(head_blk[w.file_index]);
      for (steps = 0; steps < N_BLOCKS; steps++) begin
        if (cur < MIN_BLOCK) break;
        nxt = 32'(link_tbl[cur]);
        link_tbl[cur] = LINK_FREE;
        cur = nxt;
      end
      head_blk[w.file_index]   = '0;
      file_bytes[w.file_index] = '0;
      res.ok = 1'b1;
      res.entry_now_unused = 1'b1;
      return res;
    end
    if (w.entry_status != ST_OPEN) return res;
    need   = (w.req_bytes + BLOCK_SZ - 1) / BLOCK_SZ;
    lowest = (min_alloc_blk < MIN_BLOCK) ? 32'(MIN_BLOCK) : 32'(min_alloc_blk);
    prev   = 0;
    start  = lowest;
    if (head_blk[w.file_index] != 0) begin
      // A walk ends at a link that cannot be a block number, or after one
      // pass over the table; the block reached last is the tail.
      cur = 32'(head_blk[w.file_index]);
      for (steps = 0; steps < N_BLOCKS; steps++) begin
        nxt = 32'(link_tbl[cur]);
        if (nxt < MIN_BLOCK) break;
        cur = nxt;
      end
      prev  = cur;
      start = (cur + 1 < lowest) ? lowest : cur + 1;
    end
    got = 0;
    for (b = start; b < N_BLOCKS && got < need; b++) begin
      if (link_tbl[b] == LINK_FREE) begin
        link_tbl[b] = LINK_LAST;
        if (prev != 0) link_tbl[prev] = b[7:0];
        else head_blk[w.file_index] = b[7:0];
        prev = b;
        got++;
      end
    end
    granted = got * BLOCK_SZ;
    if (granted > w.req_bytes) granted = 32'(w.req_bytes);
    total = file_bytes[w.file_index] + granted;
    if (total > 16'hFFFF) total = 16'hFFFF;
    file_bytes[w.file_index] = total[15:0];
    res.ok = 1'b1;
    res.bytes_granted = granted[15:0];
    return res;
  endfunction

  function automatic in_word_t make_word(input logic f, input int fi,
                                         input logic [ST_W-1:0] st, input int nbytes);
    in_word_t w;
    w.func         = f;
    w.file_index   = fi[FI_W-1:0];
    w.entry_status = st;
    w.req_bytes    = nbytes[SIZE_W-1:0];
    return w;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Valid stays high across back-to-back words; it is lowered only for a gap
  // or by wait_drained.
  task automatic send_word(input in_word_t w);
    int gap;
    in_data_i  <= w;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    alloc_results.push_back(predict_alloc(w));
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (alloc_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_first_usable(input logic [7:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    min_alloc_blk = v;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Rejects, files without blocks, growth of a chain and freeing it.
  task automatic test_basic_ops();
    send_word(make_word(FUNC_EXTEND, 0, ST_OPEN, 0));
    send_word(make_word(FUNC_EXTEND, 0, ST_OPEN, 1));
    send_word(make_word(FUNC_EXTEND, 0, ST_OPEN, 128));
    send_word(make_word(FUNC_EXTEND, 31, ST_OPEN, 129));
    send_word(make_word(FUNC_EXTEND, 0, ST_OPEN, 300));
    send_word(make_word(FUNC_DELETE, 5, ST_CLOSED, 16'hFFFF));
    send_word(make_word(FUNC_DELETE, 0, ST_OPEN, 0));
    send_word(make_word(FUNC_DELETE, 0, ST_UNUSED, 0));
    send_word(make_word(FUNC_DELETE, 0, ST_BAD, 0));
    send_word(make_word(FUNC_EXTEND, 1, ST_CLOSED, 200));
    send_word(make_word(FUNC_EXTEND, 1, ST_UNUSED, 200));
    send_word(make_word(FUNC_EXTEND, 1, ST_BAD, 200));
    send_word(make_word(FUNC_DELETE, 0, ST_CLOSED, 0));
    send_word(make_word(FUNC_EXTEND, 7, ST_OPEN, 32768));
    wait_drained();
  endtask

  // Fill the table to its end, then ask for more when nothing is free.
  task automatic test_table_end();
    send_word(make_word(FUNC_EXTEND, 2, ST_OPEN, 16'hFFFF));
    send_word(make_word(FUNC_EXTEND, 3, ST_OPEN, 1));
    send_word(make_word(FUNC_EXTEND, 2, ST_OPEN, 1));
    send_word(make_word(FUNC_DELETE, 2, ST_CLOSED, 0));
    send_word(make_word(FUNC_DELETE, 3, ST_CLOSED, 0));
    send_word(make_word(FUNC_DELETE, 7, ST_CLOSED, 0));
    send_word(make_word(FUNC_DELETE, 31, ST_CLOSED, 0));
    wait_drained();
  endtask

  task automatic test_first_usable_block();
    write_first_usable(8'd255);
    send_word(make_word(FUNC_EXTEND, 4, ST_OPEN, 384));
    send_word(make_word(FUNC_EXTEND, 4, ST_OPEN, 10));
    send_word(make_word(FUNC_DELETE, 4, ST_CLOSED, 0));
    wait_drained();
    write_first_usable(8'd0);
    send_word(make_word(FUNC_EXTEND, 6, ST_OPEN, 200));
    wait_drained();
    write_first_usable(8'd1);
    send_word(make_word(FUNC_EXTEND, 6, ST_OPEN, 100));
    wait_drained();
    // The tail sits below the new floor, so the search starts at the floor.
    write_first_usable(8'd130);
    send_word(make_word(FUNC_EXTEND, 6, ST_OPEN, 50));
    send_word(make_word(FUNC_EXTEND, 6, ST_OPEN, 700));
    send_word(make_word(FUNC_DELETE, 6, ST_CLOSED, 0));
    wait_drained();
    write_first_usable(CFG_RESET);
  endtask

  // The receiver stalls for a long stretch while words keep coming, so the
  // block fills and holds off its input.
  task automatic test_output_stall();
    int i;
    rx_hold_req = 400;
    for (i = 0; i < 6; i++)
      send_word(make_word(FUNC_EXTEND, 8 + i, ST_OPEN, $urandom_range(1, 400)));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_words, input bit with_idle);
    in_word_t w;
    int r, s;
    idle_on = with_idle;
    repeat (n_words) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      w.file_index = FI_W'($urandom_range(0, N_FILES - 1));
      if (s < 10) w.req_bytes = SIZE_W'(BLOCK_SZ * $urandom_range(0, 8));
      else if (s < 75) w.req_bytes = SIZE_W'($urandom_range(1, 1024));
      else if (s < 95) w.req_bytes = SIZE_W'($urandom_range(1025, 8192));
      else w.req_bytes = SIZE_W'($urandom_range(0, 65535));
      if (r < 45) begin
        w.func = FUNC_EXTEND;
        w.entry_status = ST_OPEN;
      end else if (r < 80) begin
        w.func = FUNC_DELETE;
        w.entry_status = ST_CLOSED;
      end else begin
        w.func = 1'($urandom_range(0, 1));
        w.entry_status = ST_W'($urandom_range(0, 3));
      end
      send_word(w);
    end
    wait_drained();
    idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < N_BLOCKS; i++) link_tbl[i] = LINK_FREE;
    for (int i = 0; i < N_FILES; i++) begin
      head_blk[i]   = '0;
      file_bytes[i] = '0;
    end
    min_alloc_blk = CFG_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_first_usable(CFG_RESET);
    test_basic_ops();
    test_table_end();
    test_first_usable_block();
    test_output_stall();
    test_random_traffic(160, 1'b1);
    test_random_traffic(80, 1'b0);
    write_first_usable(8'd0);
    test_random_traffic(80, 1'b1);
    write_first_usable(8'd77);
    test_random_traffic(100, 1'b1);
    write_first_usable(8'd250);
    test_random_traffic(40, 1'b1);
    write_first_usable(8'd1);
    test_random_traffic(60, 1'b1);

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatches == 0 && alloc_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req > 0) begin
        rx_stall = rx_hold_req;
        rx_hold_req = 0;
      end else if (rx_stall == 0 && idle_on && $urandom_range(0, 3) == 0) begin
        rx_stall = pick_gap();
      end
      if (rx_stall > 0) begin
        out_ready_i <= 1'b0;
        rx_stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (alloc_results.size() == 0) begin
        flag_mismatch("result word with none expected", 0, 1);
      end else begin
        if (out_data_o.ok != alloc_results[0].ok)
          flag_mismatch("ok", 32'(alloc_results[0].ok), 32'(out_data_o.ok));
        if (out_data_o.bytes_granted != alloc_results[0].bytes_granted)
          flag_mismatch("bytes_granted", 32'(alloc_results[0].bytes_granted),
                        32'(out_data_o.bytes_granted));
        if (out_data_o.entry_now_unused != alloc_results[0].entry_now_unused)
          flag_mismatch("entry_now_unused", 32'(alloc_results[0].entry_now_unused),
                        32'(out_data_o.entry_now_unused));
        void'(alloc_results.pop_front());
      end
    end
  end

  // Ends the run when no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
